[hw/rtl/scr_pkg.sv]
// shared types, constants and the tone curve builder for the splat/cut raster engine
`default_nettype none

package scr_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_CUT   = 2'd1,
    CMD_BEAD  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_SPAN,
    ST_BASE,
    ST_ROW_A,
    ST_ROW_B,
    ST_CUT_A,
    ST_CUT_B,
    ST_CUT_C,
    ST_BD_SQ,
    ST_BD_N,
    ST_BD_DIV,
    ST_BD_K,
    ST_BD_P,
    ST_BD_U,
    ST_BD_CH,
    ST_BD_WR,
    ST_ADV,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_TN_ADDR,
    ST_TN_DATA,
    ST_DONE
  } state_t;

  // signed pixel delta width (x*16 - center, frame up to 4096 wide)
  localparam int DELTA_W = 18;
  // falloff divider: r^2 fits 24 bits, quotient q16 fits 17 bits
  localparam int DEN_W = 24;
  localparam int QUO_W = 17;
  // shaping s16 = q16*(45*65536 + 55*q16) / (100*65536)
  localparam int KQ_BASE = 2949120;
  localparam int KQ_MUL = 55;
  localparam int P_SHIFT = 18;
  // reciprocal of 25 in Q26, exact for the shaped range
  localparam int RECIP25 = 2684355;
  localparam int RECIP_SHIFT = 26;
  // bead sample = color*weight*s16 >> 26
  localparam int BEAD_SHIFT = 26;
  // bounding boxes are kept in Q18 (Q4 position times Q14 direction)
  localparam int DIR_SHIFT = 14;
  localparam int SPAN_SHIFT = 18;
  // tone curve
  localparam int TONE_DEPTH = 1024;
  localparam int TONE_MAX = 1023;
  localparam logic [95:0] EXP_STEP_Q32 = 96'd4278222763;

  typedef logic [7:0] tone_tab_t [TONE_DEPTH];

  // entry i = floor(255*(1-exp(-i/256))), built by Q0.32 decay steps
  function automatic tone_tab_t tone_build();
    tone_tab_t t;
    logic [95:0] v;
    logic [95:0] d;
    v = 96'd1 << 32;
    for (int i = 0; i < TONE_DEPTH; i++) begin
      d = (96'd255 * ((96'd1 << 32) - v)) >> 32;
      t[i] = d[7:0];
      v = (v * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/scr_frame_mem.sv]
// frame store: single-port-write, registered-read synchronous memory
`default_nettype none

module scr_frame_mem #(
  parameter int DEPTH = 172800,
  parameter int AW    = 18,
  parameter int DW    = 36
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered and held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/scr_tone_rom.sv]
// tone curve rom with registered read
`default_nettype none

module scr_tone_rom (
  input  wire logic       clk,
  input  wire logic [9:0] addr,
  output logic      [7:0] data
);

  localparam scr_pkg::tone_tab_t TONE = scr_pkg::tone_build();

  // registered lookup
  always_ff @(posedge clk) begin
    data <= TONE[addr];
  end

endmodule

`default_nettype wire

[hw/rtl/scr_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module scr_div #(
  parameter int DEN_W = 24,
  parameter int QUO_W = 17
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [DEN_W+QUO_W-1:0] num,
  input  wire logic [DEN_W-1:0]       den,
  output logic                        done,
  output logic      [QUO_W-1:0]       quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // trial subtract of the next shifted-in bit
  assign trial = {rem, sh[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quo   = sh;

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUO_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[DEN_W+QUO_W-1:QUO_W];
      sh    <= num[QUO_W-1:0];
      den_r <= den;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      sh <= {sh[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/splat_cut_raster_engine.sv]
// splat/cut raster engine top level: command sequencer over the frame store
// Clear: zero to every frame word, one frame word per cycle. Read: one pixel fetch, then a tone
// lookup per channel (outputs stay zero off frame). Cut: setup, row multiply steps per box row,
// pixel multiply steps and a slab-test write per box pixel. Bead: the same setup and rows; each
// covered pixel runs the divider, shaping and a per-channel max write. One item at a time; done
// marks the single result cycle, the receiver cannot stall, and reset starts a busy clearing pass.
`default_nettype none

module splat_cut_raster_engine #(
  parameter int FRAME_WIDTH  = 480,
  parameter int FRAME_HEIGHT = 360,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [13:0] x_pos,
  input  wire logic signed [13:0] y_pos,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic [11:0]        size_a,
  input  wire logic [11:0]        size_b,
  input  wire logic [9:0]         red,
  input  wire logic [9:0]         green,
  input  wire logic [9:0]         blue,
  input  wire logic [10:0]        weight,
  output logic                    done,
  output logic                    read_valid,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int SB     = SAMPLE_BITS;
  localparam int PW     = 3 * SB;
  localparam int CRD_W  = $clog2(((FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT) + 1);
  localparam int CW     = scr_pkg::DELTA_W;
  localparam int DNW    = scr_pkg::DEN_W;
  localparam int QW     = scr_pkg::QUO_W;
  localparam logic [16:0] SMAX = 17'((1 << SAMPLE_BITS) - 1);

  scr_pkg::state_t state, state_next;

  // captured item
  scr_pkg::cmd_t      cmd_r;
  logic signed [13:0] cx, cy;
  logic signed [15:0] ux, uy;
  logic [11:0]        sa, sb;
  logic [9:0]         col [3];
  logic [10:0]        wt;

  // control
  logic [1:0]       sk;
  logic [1:0]       ch;
  logic [1:0]       tch;
  logic [AW-1:0]    clr_addr;
  logic             clr_cmd;
  logic [CRD_W-1:0] xc, yc, x0, x1, y1;
  logic [AW-1:0]    row_base;

  // datapath
  logic [28:0]            ex, ey;
  logic [DNW-1:0]         r2;
  logic [20:0]            cw [3];
  logic signed [35:0]     rowp1, rowp2, pa, pb;
  logic [PW-1:0]          old_pix, new_pix;
  logic [QW-1:0]          q16;
  logic [22:0]            kq;
  logic [39:0]            prod_p;
  logic [42:0]            u_r;
  logic [7:0]             out_r [3];
  logic                   rv_r;

  // combinational
  logic                   accept;
  logic                   is_cut;
  logic [11:0]            su_a;
  logic [15:0]            su_b;
  logic [27:0]            su_p;
  logic [15:0]            aux, auy;
  logic signed [31:0]     ext_x, ext_y, c14x, c14y;
  logic [CRD_W-1:0]       sx0, sx1, sy0, sy1;
  logic signed [CW-1:0]   dx, dy;
  logic signed [CW-1:0]   pm_a, pm_b;
  logic signed [35:0]     pm_p;
  logic signed [37:0]     cut_a, cut_b, abs_a, abs_b;
  logic                   in_slab;
  logic signed [37:0]     bead_n;
  logic                   n_pos;
  logic                   div_start, div_done;
  logic [QW-1:0]          div_q;
  logic [16:0]            s16;
  logic [37:0]            ch_prod;
  logic [16:0]            v_raw, v_sat;
  logic [SB-1:0]          v_new, s_old, s_tone;
  logic [16:0]            t_shift;
  logic [9:0]             rom_addr;
  logic [7:0]             rom_data;
  logic                   x_more, y_more;
  logic [8:0]             rd_px, rd_py;
  logic                   rd_ok;
  logic [AW-1:0]          rd_pix_addr;
  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  logic [PW-1:0]          mem_wdata, mem_rdata;

  // box clip helpers, positions in Q18
  function automatic logic [CRD_W-1:0] span_lo(input logic signed [31:0] v, input int lim);
    logic signed [31:0] s;
    s = (v < 0) ? 32'sd0 : (v >>> scr_pkg::SPAN_SHIFT);
    if (s > lim) s = lim;
    return CRD_W'(s);
  endfunction

  function automatic logic [CRD_W-1:0] span_hi(input logic signed [31:0] v, input int lim);
    logic signed [31:0] s;
    s = (v < 0) ? 32'sd0 : (v >>> scr_pkg::SPAN_SHIFT) + 32'sd1;
    if (s > lim) s = lim;
    return CRD_W'(s);
  endfunction

  assign accept = start && (state == scr_pkg::ST_IDLE);
  assign busy   = (state != scr_pkg::ST_IDLE);
  assign is_cut = (cmd_r == scr_pkg::CMD_CUT);

  assign read_valid = rv_r;
  assign red_out    = out_r[0];
  assign green_out  = out_r[1];
  assign blue_out   = out_r[2];

  // setup multiplier: box extents for cut, r^2 and color*weight for bead
  assign aux = ux[15] ? 16'(-ux) : 16'(ux);
  assign auy = uy[15] ? 16'(-uy) : 16'(uy);
  always_comb begin
    su_a = sa;
    su_b = aux;
    if (is_cut) begin
      case (sk)
        2'd0: begin su_a = sa; su_b = aux; end
        2'd1: begin su_a = sb; su_b = auy; end
        2'd2: begin su_a = sa; su_b = auy; end
        default: begin su_a = sb; su_b = aux; end
      endcase
    end else begin
      case (sk)
        2'd0: begin su_a = sb; su_b = 16'(sb); end
        2'd1: begin su_a = 12'(col[0]); su_b = 16'(wt); end
        2'd2: begin su_a = 12'(col[1]); su_b = 16'(wt); end
        default: begin su_a = 12'(col[2]); su_b = 16'(wt); end
      endcase
    end
  end
  assign su_p = su_a * su_b;

  // bounding box in pixels
  assign c14x  = 32'(cx) <<< scr_pkg::DIR_SHIFT;
  assign c14y  = 32'(cy) <<< scr_pkg::DIR_SHIFT;
  assign ext_x = is_cut ? $signed({3'b000, ex}) : $signed({6'd0, sb, 14'd0});
  assign ext_y = is_cut ? $signed({3'b000, ey}) : $signed({6'd0, sb, 14'd0});
  assign sx0 = span_lo(c14x - ext_x, FRAME_WIDTH);
  assign sx1 = span_hi(c14x + ext_x, FRAME_WIDTH);
  assign sy0 = span_lo(c14y - ext_y, FRAME_HEIGHT);
  assign sy1 = span_hi(c14y + ext_y, FRAME_HEIGHT);

  // pixel deltas from the center, Q4
  assign dx = CW'($signed({1'b0, xc, 4'b0000})) - CW'(cx);
  assign dy = CW'($signed({1'b0, yc, 4'b0000})) - CW'(cy);

  // shared pixel multiplier
  assign pm_p = pm_a * pm_b;

  // slab test
  assign cut_a   = 38'(pa) + 38'(rowp1);
  assign cut_b   = 38'(rowp2) - 38'(pb);
  assign abs_a   = (cut_a < 0) ? -cut_a : cut_a;
  assign abs_b   = (cut_b < 0) ? -cut_b : cut_b;
  assign in_slab = (abs_a <= $signed({12'd0, sa, 14'd0})) &&
                   (abs_b <= $signed({12'd0, sb, 14'd0}));

  // bead coverage n = r^2 - d^2
  assign bead_n = $signed({14'd0, r2}) - 38'(pa) - 38'(rowp1);
  assign n_pos  = bead_n > 0;

  scr_div #(
    .DEN_W (DNW),
    .QUO_W (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({1'b0, bead_n[DNW-1:0], (QW-1)'(0)}),
    .den   (r2),
    .done  (div_done),
    .quo   (div_q)
  );

  // per-channel bead sample, saturated
  assign s16     = u_r[42:26];
  assign ch_prod = 38'(cw[ch]) * 38'(s16);
  assign v_raw   = 17'(ch_prod >> scr_pkg::BEAD_SHIFT);
  assign v_sat   = (v_raw > SMAX) ? SMAX : v_raw;
  assign v_new   = v_sat[SB-1:0];
  assign s_old   = old_pix[ch*SB +: SB];

  // tone index of the selected channel
  assign s_tone   = old_pix[tch*SB +: SB];
  assign t_shift  = 17'(s_tone) >> 2;
  assign rom_addr = (t_shift > 17'(scr_pkg::TONE_MAX)) ? 10'(scr_pkg::TONE_MAX) : t_shift[9:0];

  scr_tone_rom u_tone (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // read pixel address
  assign rd_px       = cx[12:4];
  assign rd_py       = cy[12:4];
  assign rd_ok       = !cx[13] && !cy[13] && (32'(rd_px) < FRAME_WIDTH) &&
                       (32'(rd_py) < FRAME_HEIGHT);
  assign rd_pix_addr = AW'(32'(rd_py) * FRAME_WIDTH + 32'(rd_px));

  // scan loop tests
  assign x_more = (({1'b0, xc}) + 1'b1) < {1'b0, x1};
  assign y_more = (({1'b0, yc}) + 1'b1) < {1'b0, y1};

  scr_frame_mem #(
    .DEPTH (PIXELS),
    .AW    (AW),
    .DW    (PW)
  ) u_frame (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      scr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (scr_pkg::cmd_t'(cmd)) inside
            scr_pkg::CMD_CLEAR: state_next = scr_pkg::ST_CLEAR;
            scr_pkg::CMD_CUT,
            scr_pkg::CMD_BEAD:  state_next = scr_pkg::ST_SETUP;
            default:            state_next = scr_pkg::ST_RD_ADDR;
          endcase
        end
      end
      scr_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(PIXELS - 1)) begin
          state_next = clr_cmd ? scr_pkg::ST_DONE : scr_pkg::ST_IDLE;
        end
      end
      scr_pkg::ST_SETUP: if (sk == 2'd3) state_next = scr_pkg::ST_SPAN;
      scr_pkg::ST_SPAN:  state_next = scr_pkg::ST_BASE;
      scr_pkg::ST_BASE: begin
        if ((x0 >= x1) || (yc >= y1) || (!is_cut && (sb == 12'd0))) begin
          state_next = scr_pkg::ST_DONE;
        end else begin
          state_next = scr_pkg::ST_ROW_A;
        end
      end
      scr_pkg::ST_ROW_A: state_next = scr_pkg::ST_ROW_B;
      scr_pkg::ST_ROW_B: state_next = is_cut ? scr_pkg::ST_CUT_A : scr_pkg::ST_BD_SQ;
      scr_pkg::ST_CUT_A: state_next = scr_pkg::ST_CUT_B;
      scr_pkg::ST_CUT_B: state_next = scr_pkg::ST_CUT_C;
      scr_pkg::ST_CUT_C: state_next = scr_pkg::ST_ADV;
      scr_pkg::ST_BD_SQ: state_next = scr_pkg::ST_BD_N;
      scr_pkg::ST_BD_N:  state_next = n_pos ? scr_pkg::ST_BD_DIV : scr_pkg::ST_ADV;
      scr_pkg::ST_BD_DIV: if (div_done) state_next = scr_pkg::ST_BD_K;
      scr_pkg::ST_BD_K:  state_next = scr_pkg::ST_BD_P;
      scr_pkg::ST_BD_P:  state_next = scr_pkg::ST_BD_U;
      scr_pkg::ST_BD_U:  state_next = scr_pkg::ST_BD_CH;
      scr_pkg::ST_BD_CH: if (ch == 2'd2) state_next = scr_pkg::ST_BD_WR;
      scr_pkg::ST_BD_WR: state_next = scr_pkg::ST_ADV;
      scr_pkg::ST_ADV: begin
        if (x_more) begin
          state_next = is_cut ? scr_pkg::ST_CUT_A : scr_pkg::ST_BD_SQ;
        end else if (y_more) begin
          state_next = scr_pkg::ST_ROW_A;
        end else begin
          state_next = scr_pkg::ST_DONE;
        end
      end
      scr_pkg::ST_RD_ADDR: state_next = rd_ok ? scr_pkg::ST_RD_DATA : scr_pkg::ST_DONE;
      scr_pkg::ST_RD_DATA: state_next = scr_pkg::ST_TN_ADDR;
      scr_pkg::ST_TN_ADDR: state_next = scr_pkg::ST_TN_DATA;
      scr_pkg::ST_TN_DATA: state_next = (tch == 2'd2) ? scr_pkg::ST_DONE : scr_pkg::ST_TN_ADDR;
      scr_pkg::ST_DONE:    state_next = scr_pkg::ST_IDLE;
      default:             state_next = scr_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory ports, multiplier operands, divider start, strobe
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_base + AW'(xc);
    mem_we    = 1'b0;
    mem_waddr = row_base + AW'(xc);
    mem_wdata = '0;
    pm_a      = dx;
    pm_b      = CW'(ux);
    div_start = 1'b0;
    done      = 1'b0;
    unique case (state)
      scr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      scr_pkg::ST_ROW_A: begin
        pm_a = dy;
        pm_b = is_cut ? CW'(uy) : dy;
      end
      scr_pkg::ST_ROW_B: begin
        pm_a = dy;
        pm_b = CW'(ux);
      end
      scr_pkg::ST_CUT_A: begin
        pm_a = dx;
        pm_b = CW'(ux);
      end
      scr_pkg::ST_CUT_B: begin
        pm_a = dx;
        pm_b = CW'(uy);
      end
      scr_pkg::ST_CUT_C: mem_we = in_slab;
      scr_pkg::ST_BD_SQ: begin
        pm_a   = dx;
        pm_b   = dx;
        mem_re = 1'b1;
      end
      scr_pkg::ST_BD_N:  div_start = n_pos;
      scr_pkg::ST_BD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = new_pix;
      end
      scr_pkg::ST_RD_ADDR: begin
        mem_re    = 1'b1;
        mem_raddr = rd_pix_addr;
      end
      scr_pkg::ST_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= scr_pkg::ST_CLEAR;
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
      sk       <= '0;
      ch       <= '0;
      tch      <= '0;
      xc       <= '0;
      yc       <= '0;
      x0       <= '0;
      x1       <= '0;
      y1       <= '0;
      row_base <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        scr_pkg::ST_IDLE: begin
          sk       <= '0;
          clr_addr <= '0;
          clr_cmd  <= 1'b1;
        end
        scr_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        scr_pkg::ST_SETUP: sk <= sk + 1'b1;
        scr_pkg::ST_SPAN: begin
          x0 <= sx0;
          x1 <= sx1;
          y1 <= sy1;
          xc <= sx0;
          yc <= sy0;
        end
        scr_pkg::ST_BASE: row_base <= AW'(yc * FRAME_WIDTH);
        scr_pkg::ST_BD_U: ch <= '0;
        scr_pkg::ST_BD_CH: ch <= ch + 1'b1;
        scr_pkg::ST_ADV: begin
          if (x_more) begin
            xc <= xc + 1'b1;
          end else begin
            xc       <= x0;
            yc       <= yc + 1'b1;
            row_base <= row_base + AW'(FRAME_WIDTH);
          end
        end
        scr_pkg::ST_RD_DATA: tch <= '0;
        scr_pkg::ST_TN_DATA: tch <= tch + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // item capture and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= scr_pkg::cmd_t'(cmd);
      cx       <= x_pos;
      cy       <= y_pos;
      ux       <= dir_x;
      uy       <= dir_y;
      sa       <= size_a;
      sb       <= size_b;
      col[0]   <= red;
      col[1]   <= green;
      col[2]   <= blue;
      wt       <= weight;
      rv_r     <= (scr_pkg::cmd_t'(cmd) == scr_pkg::CMD_READ);
      out_r[0] <= '0;
      out_r[1] <= '0;
      out_r[2] <= '0;
    end
    case (state)
      scr_pkg::ST_SETUP: begin
        if (is_cut) begin
          case (sk)
            2'd0:    ex <= 29'(su_p);
            2'd1:    ex <= ex + 29'(su_p);
            2'd2:    ey <= 29'(su_p);
            default: ey <= ey + 29'(su_p);
          endcase
        end else begin
          case (sk)
            2'd0:    r2    <= su_p[DNW-1:0];
            2'd1:    cw[0] <= su_p[20:0];
            2'd2:    cw[1] <= su_p[20:0];
            default: cw[2] <= su_p[20:0];
          endcase
        end
      end
      scr_pkg::ST_ROW_A: rowp1 <= pm_p;
      scr_pkg::ST_ROW_B: rowp2 <= pm_p;
      scr_pkg::ST_CUT_A: pa <= pm_p;
      scr_pkg::ST_CUT_B: pb <= pm_p;
      scr_pkg::ST_BD_SQ: pa <= pm_p;
      scr_pkg::ST_BD_N: begin
        old_pix <= mem_rdata;
        new_pix <= mem_rdata;
      end
      scr_pkg::ST_BD_DIV: if (div_done) q16 <= div_q;
      scr_pkg::ST_BD_K: kq <= 23'(scr_pkg::KQ_BASE) + 23'(scr_pkg::KQ_MUL) * 23'(q16);
      scr_pkg::ST_BD_P: prod_p <= 40'(q16) * 40'(kq);
      scr_pkg::ST_BD_U: u_r <= 43'(prod_p[39:scr_pkg::P_SHIFT]) * 43'(scr_pkg::RECIP25);
      scr_pkg::ST_BD_CH: begin
        if (s_old < v_new) begin
          new_pix[ch*SB +: SB] <= v_new;
        end
      end
      scr_pkg::ST_RD_DATA: old_pix <= mem_rdata;
      scr_pkg::ST_TN_DATA: out_r[tch] <= rom_data;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
